/* hw/rtl/lcsf_pkg.sv */
package lcsf_pkg;

  localparam int OP_W    = 4;
  localparam int CH_W    = 6;
  localparam int CAUSE_W = 4;
  localparam int ACT_W   = 4;
  localparam int ST_W    = 3;

  localparam int CH_SPAN = 1 << CH_W;

  typedef enum logic [OP_W-1:0] {
    OP_EST_REQ   = 4'd0,
    OP_REL_REQ   = 4'd1,
    OP_OPEN_ACK  = 4'd2,
    OP_OPEN_REJ  = 4'd3,
    OP_CLOSE_ACK = 4'd4,
    OP_EST_RESP  = 4'd5,
    OP_EST_REJ   = 4'd6,
    OP_OPEN_RX   = 4'd7,
    OP_CLOSE_RX  = 4'd8,
    OP_OPEN_CONF = 4'd9
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_REFUSED    = 4'd0,
    ACT_ACCEPTED   = 4'd1,
    ACT_SEND_OPEN  = 4'd2,
    ACT_SEND_CLOSE = 4'd3,
    ACT_OPEN_ACK   = 4'd4,
    ACT_OPEN_REJ   = 4'd5,
    ACT_CLOSE_ACK  = 4'd6,
    ACT_EST_IND    = 4'd7,
    ACT_EST_CONF   = 4'd8,
    ACT_REL_IND    = 4'd9,
    ACT_REL_CONF   = 4'd10,
    ACT_ERROR      = 4'd11
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_ABSENT      = 3'd0,
    ST_RELEASED    = 3'd1,
    ST_AWAIT_EST   = 3'd2,
    ST_ESTABLISHED = 3'd3,
    ST_AWAIT_REL   = 3'd4
  } lc_state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic sel2;
  } lcsf_cmd_t;

  typedef struct packed {
    logic two;
  } lcsf_sts_t;

endpackage

/* hw/rtl/lcsf_ifs.sv */
interface lcsf_in_if import lcsf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [CH_W-1:0]    channel;
  logic               build_ok;
  logic [CAUSE_W-1:0] reject_cause;

  modport source(output valid, output operation, output channel, output build_ok,
                 output reject_cause, input ready);
  modport sink(input valid, input operation, input channel, input build_ok,
               input reject_cause, output ready);
endinterface

interface lcsf_out_if import lcsf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [CH_W-1:0]    channel_out;
  logic [CAUSE_W-1:0] cause_out;
  logic               last;

  modport source(output valid, output action, output channel_out, output cause_out,
                 output last, input ready);
  modport sink(input valid, input action, input channel_out, input cause_out,
               input last, output ready);
endinterface

/* hw/rtl/lcsf_ctrl.sv */
module lcsf_ctrl import lcsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lcsf_sts_t sts,
  output lcsf_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_SEND1 = 4'b0100,
    S_SEND2 = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.update  = 1'b0;
    cmd.sel2    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.update = 1'b1;
        state_nxt  = S_SEND1;
      end
      S_SEND1: begin
        out_valid = 1'b1;
        in_ready  = out_ready && !sts.two;
        if (out_ready) begin
          if (sts.two) state_nxt = S_SEND2;
          else state_nxt = in_valid ? S_CALC : S_IDLE;
        end
      end
      S_SEND2: begin
        out_valid = 1'b1;
        cmd.sel2  = 1'b1;
        in_ready  = out_ready;
        if (out_ready) state_nxt = in_valid ? S_CALC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.capture = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* hw/rtl/lcsf_dp.sv */
module lcsf_dp import lcsf_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lcsf_cmd_t          cmd,
  output lcsf_sts_t          sts,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [CH_W-1:0]    in_channel,
  input  logic               in_build_ok,
  input  logic [CAUSE_W-1:0] in_reject_cause,
  output logic [ACT_W-1:0]   out_action,
  output logic [CH_W-1:0]    out_channel,
  output logic [CAUSE_W-1:0] out_cause,
  output logic               out_last
);

  localparam int DEPTH = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
  localparam int AW    = $clog2(DEPTH);

  logic [ST_W-1:0] out_tab [DEPTH];
  logic [ST_W-1:0] inc_tab [DEPTH];
  logic [DEPTH-1:0] out_vld_r;
  logic [DEPTH-1:0] inc_vld_r;

  logic [OP_W-1:0]    op_r;
  logic [CH_W-1:0]    ch_r;
  logic               build_r;
  logic [CAUSE_W-1:0] cause_r;
  logic               in_range_r;
  logic [ST_W-1:0]    o_rd_r, i_rd_r;
  logic               o_vld_rd_r, i_vld_rd_r;

  logic [ACT_W-1:0]   a1_r, a2_r;
  logic [CAUSE_W-1:0] cause_o_r;
  logic               two_r;

  logic [AW-1:0]   rd_idx, wr_idx;
  logic [ST_W-1:0] o_s, i_s, o_nxt, i_nxt, s_tmp;
  logic [ACT_W-1:0] a1, a2;
  logic             two;

  assign rd_idx = in_channel[AW-1:0];
  assign wr_idx = ch_r[AW-1:0];
  assign o_s    = o_vld_rd_r ? o_rd_r : ST_ABSENT;
  assign i_s    = i_vld_rd_r ? i_rd_r : ST_ABSENT;

  always_comb begin
    a1    = ACT_REFUSED;
    a2    = ACT_REFUSED;
    two   = 1'b0;
    o_nxt = o_s;
    i_nxt = i_s;
    s_tmp = ST_ABSENT;
    unique case (op_r)
      OP_EST_REQ: begin
        s_tmp = (o_s == ST_ABSENT) ? ST_RELEASED : o_s;
        o_nxt = s_tmp;
        if ((s_tmp == ST_RELEASED || s_tmp == ST_AWAIT_REL) && build_r) begin
          o_nxt = ST_AWAIT_EST;
          a1    = ACT_SEND_OPEN;
        end
      end
      OP_REL_REQ: begin
        if (o_s == ST_AWAIT_EST || o_s == ST_ESTABLISHED) begin
          o_nxt = ST_AWAIT_REL;
          a1    = ACT_SEND_CLOSE;
        end
      end
      OP_OPEN_ACK: begin
        if (o_s == ST_RELEASED) a1 = ACT_ERROR;
        else if (o_s == ST_AWAIT_EST) begin
          o_nxt = ST_ESTABLISHED;
          a1    = ACT_EST_CONF;
        end else if (o_s == ST_ESTABLISHED || o_s == ST_AWAIT_REL) a1 = ACT_ACCEPTED;
      end
      OP_OPEN_REJ, OP_CLOSE_ACK: begin
        if (o_s == ST_RELEASED) begin
          a1 = (op_r == OP_OPEN_REJ) ? ACT_ERROR : ACT_ACCEPTED;
        end else if (o_s == ST_AWAIT_EST) begin
          if (op_r == OP_OPEN_REJ) begin
            o_nxt = ST_RELEASED;
            a1    = ACT_REL_IND;
          end else a1 = ACT_ACCEPTED;
        end else if (o_s == ST_ESTABLISHED) begin
          o_nxt = ST_RELEASED;
          a1    = ACT_ERROR;
          a2    = ACT_REL_IND;
          two   = 1'b1;
        end else if (o_s == ST_AWAIT_REL) begin
          o_nxt = ST_RELEASED;
          a1    = ACT_REL_CONF;
        end
      end
      OP_EST_RESP: begin
        if (i_s == ST_AWAIT_EST) begin
          i_nxt = ST_ESTABLISHED;
          a1    = ACT_OPEN_ACK;
        end
      end
      OP_EST_REJ: begin
        if (i_s == ST_AWAIT_EST) begin
          i_nxt = ST_RELEASED;
          a1    = ACT_OPEN_REJ;
        end
      end
      OP_OPEN_RX: begin
        s_tmp = (i_s == ST_ABSENT) ? ST_RELEASED : i_s;
        i_nxt = s_tmp;
        if (s_tmp == ST_RELEASED) begin
          i_nxt = ST_AWAIT_EST;
          a1    = ACT_EST_IND;
        end else if (s_tmp == ST_AWAIT_EST || s_tmp == ST_ESTABLISHED) begin
          i_nxt = ST_AWAIT_EST;
          a1    = ACT_REL_IND;
          a2    = ACT_EST_IND;
          two   = 1'b1;
        end
      end
      OP_CLOSE_RX: begin
        if (i_s == ST_AWAIT_EST || i_s == ST_ESTABLISHED) begin
          i_nxt = ST_RELEASED;
          a1    = ACT_CLOSE_ACK;
          a2    = ACT_REL_IND;
          two   = 1'b1;
        end else if (i_s == ST_RELEASED) a1 = ACT_CLOSE_ACK;
      end
      default: ;
    endcase
    if (!in_range_r) begin
      a1  = ACT_REFUSED;
      a2  = ACT_REFUSED;
      two = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      ch_r       <= in_channel;
      build_r    <= in_build_ok;
      cause_r    <= in_reject_cause;
      in_range_r <= (32'(in_channel) < 32'(CHANNELS));
      o_rd_r     <= out_tab[rd_idx];
      i_rd_r     <= inc_tab[rd_idx];
      o_vld_rd_r <= out_vld_r[rd_idx];
      i_vld_rd_r <= inc_vld_r[rd_idx];
    end
    if (cmd.update) begin
      a1_r      <= a1;
      a2_r      <= a2;
      two_r     <= two;
      cause_o_r <= (a1 == ACT_OPEN_REJ) ? cause_r : '0;
      if (in_range_r) begin
        out_tab[wr_idx] <= o_nxt;
        inc_tab[wr_idx] <= i_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= '0;
      inc_vld_r <= '0;
    end else if (cmd.update && in_range_r) begin
      out_vld_r[wr_idx] <= 1'b1;
      inc_vld_r[wr_idx] <= 1'b1;
    end
  end

  assign sts.two     = two_r;
  assign out_action  = cmd.sel2 ? a2_r : a1_r;
  assign out_channel = ch_r;
  assign out_cause   = cmd.sel2 ? '0 : cause_o_r;
  assign out_last    = cmd.sel2 || !two_r;

endmodule

/* hw/rtl/logical_channel_signalling_fsm.sv */
// Logical channel signalling state machines, one per channel and direction.
// in_ch carries one operation on one channel (operation, channel, build_ok,
// reject_cause); out_ch carries the resulting actions (action, channel_out,
// cause_out, last), one or two per operation, last set on the final one.
// Both are valid/ready channels; a transfer happens when both are high.
// An accepted operation reads both channel tables at the accept edge,
// writes them back in the calc state that follows and then shows its
// first result. The block takes no new operation while the table
// read-modify-write of one is under way or its results wait in the
// result register; the next operation is taken in the same cycle its
// predecessor's last result transfers. A stalled receiver holds the
// result steady and blocks new operations until it transfers.
// Reset clears every table entry to absent at once; the block takes an
// operation in the first cycle after reset.
module logical_channel_signalling_fsm import lcsf_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input logic         clk,
  input logic         rst_n,
  lcsf_in_if.sink     in_ch,
  lcsf_out_if.source  out_ch
);

  lcsf_cmd_t cmd;
  lcsf_sts_t sts;

  lcsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcsf_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_channel      (in_ch.channel),
    .in_build_ok     (in_ch.build_ok),
    .in_reject_cause (in_ch.reject_cause),
    .out_action      (out_ch.action),
    .out_channel     (out_ch.channel_out),
    .out_cause       (out_ch.cause_out),
    .out_last        (out_ch.last)
  );

endmodule

/* hw/rtl/lcsf_chk.sv */
module lcsf_chk import lcsf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ACT_W-1:0]   out_action,
  input logic [CH_W-1:0]    out_channel,
  input logic [CAUSE_W-1:0] out_cause,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_channel) && $stable(out_cause) && $stable(out_last))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || (out_ready && out_last))
    else $error("operation taken while results pending");

  a_calc_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("no update cycle after accept");

  a_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("second result missing");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind logical_channel_signalling_fsm lcsf_chk u_lcsf_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_action  (out_ch.action),
  .out_channel (out_ch.channel_out),
  .out_cause   (out_ch.cause_out),
  .out_last    (out_ch.last)
);

/* sim/lcsf_action_checker.sv */
`timescale 1ns / 100ps

module lcsf_action_checker import lcsf_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input  logic clk,
  input  logic rst_n,
  lcsf_in_if   in_ch,
  lcsf_out_if  out_ch,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    act_t               action;
    logic [CH_W-1:0]    channel;
    logic [CAUSE_W-1:0] cause;
    logic               last;
  } lc_action_t;

  lc_state_t  out_st [CH_SPAN];
  lc_state_t  in_st  [CH_SPAN];
  lc_action_t expected_actions [$];

  function automatic void predict_actions(input logic [OP_W-1:0]    op,
                                          input logic [CH_W-1:0]    ch,
                                          input logic               build,
                                          input logic [CAUSE_W-1:0] cause);
    act_t a1;
    act_t a2;
    bit   two;
    a1  = ACT_REFUSED;
    a2  = ACT_REFUSED;
    two = 1'b0;
    if (int'(ch) < CHANNELS) begin
      case (op)
        OP_EST_REQ: begin
          if (out_st[ch] == ST_ABSENT) out_st[ch] = ST_RELEASED;
          if ((out_st[ch] == ST_RELEASED || out_st[ch] == ST_AWAIT_REL) && build) begin
            out_st[ch] = ST_AWAIT_EST;
            a1 = ACT_SEND_OPEN;
          end
        end
        OP_REL_REQ: begin
          if (out_st[ch] == ST_AWAIT_EST || out_st[ch] == ST_ESTABLISHED) begin
            out_st[ch] = ST_AWAIT_REL;
            a1 = ACT_SEND_CLOSE;
          end
        end
        OP_OPEN_ACK: begin
          case (out_st[ch])
            ST_RELEASED: a1 = ACT_ERROR;
            ST_AWAIT_EST: begin
              out_st[ch] = ST_ESTABLISHED;
              a1 = ACT_EST_CONF;
            end
            ST_ESTABLISHED, ST_AWAIT_REL: a1 = ACT_ACCEPTED;
            default: a1 = ACT_REFUSED;
          endcase
        end
        OP_OPEN_REJ, OP_CLOSE_ACK: begin
          case (out_st[ch])
            ST_RELEASED: a1 = (op == OP_OPEN_REJ) ? ACT_ERROR : ACT_ACCEPTED;
            ST_AWAIT_EST: begin
              if (op == OP_OPEN_REJ) begin
                out_st[ch] = ST_RELEASED;
                a1 = ACT_REL_IND;
              end else begin
                a1 = ACT_ACCEPTED;
              end
            end
            ST_ESTABLISHED: begin
              out_st[ch] = ST_RELEASED;
              a1  = ACT_ERROR;
              a2  = ACT_REL_IND;
              two = 1'b1;
            end
            ST_AWAIT_REL: begin
              out_st[ch] = ST_RELEASED;
              a1 = ACT_REL_CONF;
            end
            default: a1 = ACT_REFUSED;
          endcase
        end
        OP_EST_RESP: begin
          if (in_st[ch] == ST_AWAIT_EST) begin
            in_st[ch] = ST_ESTABLISHED;
            a1 = ACT_OPEN_ACK;
          end
        end
        OP_EST_REJ: begin
          if (in_st[ch] == ST_AWAIT_EST) begin
            in_st[ch] = ST_RELEASED;
            a1 = ACT_OPEN_REJ;
          end
        end
        OP_OPEN_RX: begin
          if (in_st[ch] == ST_ABSENT) in_st[ch] = ST_RELEASED;
          case (in_st[ch])
            ST_RELEASED: begin
              in_st[ch] = ST_AWAIT_EST;
              a1 = ACT_EST_IND;
            end
            ST_AWAIT_EST, ST_ESTABLISHED: begin
              in_st[ch] = ST_AWAIT_EST;
              a1  = ACT_REL_IND;
              a2  = ACT_EST_IND;
              two = 1'b1;
            end
            default: a1 = ACT_REFUSED;
          endcase
        end
        OP_CLOSE_RX: begin
          case (in_st[ch])
            ST_AWAIT_EST, ST_ESTABLISHED: begin
              in_st[ch] = ST_RELEASED;
              a1  = ACT_CLOSE_ACK;
              a2  = ACT_REL_IND;
              two = 1'b1;
            end
            ST_RELEASED: a1 = ACT_CLOSE_ACK;
            default: a1 = ACT_REFUSED;
          endcase
        end
        default: a1 = ACT_REFUSED;
      endcase
    end
    expected_actions.push_back('{a1, ch, (a1 == ACT_OPEN_REJ) ? cause : '0, !two});
    if (two) expected_actions.push_back('{a2, ch, '0, 1'b1});
  endfunction

  always @(posedge clk) begin
    lc_action_t got;
    lc_action_t want;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      foreach (out_st[i]) begin
        out_st[i] = ST_ABSENT;
        in_st[i]  = ST_ABSENT;
      end
      expected_actions.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_actions(in_ch.operation, in_ch.channel, in_ch.build_ok, in_ch.reject_cause);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{act_t'(out_ch.action), out_ch.channel_out, out_ch.cause_out, out_ch.last};
        if (expected_actions.size() == 0) begin
          $error("unexpected transfer: action %0d channel %0d", got.action, got.channel);
          errs++;
        end else begin
          want = expected_actions.pop_front();
          if (got.action != want.action) begin
            $error("action: expected %0d, actual %0d", want.action, got.action);
            errs++;
          end
          if (got.channel != want.channel) begin
            $error("channel_out: expected %0d, actual %0d", want.channel, got.channel);
            errs++;
          end
          if (got.cause != want.cause) begin
            $error("cause_out: expected %0d, actual %0d", want.cause, got.cause);
            errs++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errs++;
          end
        end
      end
    end
    mismatches <= mismatches + errs;
    pending    <= expected_actions.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top import lcsf_pkg::*; ();

  localparam int LONG_HOLD = 300;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   send_idle;
  int   recv_idle;
  bit   hold_out;

  lcsf_in_if  in_ch ();
  lcsf_out_if out_ch ();

  logical_channel_signalling_fsm #(.CHANNELS(64)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lcsf_action_checker #(.CHANNELS(64)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_item(input logic [OP_W-1:0]    op,
                           input logic [CH_W-1:0]    ch,
                           input logic               build,
                           input logic [CAUSE_W-1:0] cause);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.channel      <= ch;
    in_ch.build_ok     <= build;
    in_ch.reject_cause <= cause;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic random_items(input int count);
    int                sent;
    int                r;
    logic [CH_W-1:0]   ch;
    logic [OP_W-1:0]   op;
    sent = 0;
    while (sent < count) begin
      ch = ($urandom_range(9) == 0) ? CH_W'($urandom_range(CH_SPAN - 1))
                                    : CH_W'($urandom_range(7));
      r  = $urandom_range(99);
      if (r < 40) begin
        for (int k = 0; k < 4; k++) begin
          case (k)
            0:       op = OP_EST_REQ;
            1:       op = OP_OPEN_ACK;
            2:       op = OP_REL_REQ;
            default: op = OP_CLOSE_ACK;
          endcase
          if ($urandom_range(6) == 0) op = OP_W'($urandom_range(OP_CLOSE_ACK, OP_EST_REQ));
          send_item(op, ch, $urandom_range(9) != 0, CAUSE_W'($urandom_range(15)));
        end
        sent += 4;
      end else if (r < 75) begin
        for (int k = 0; k < 3; k++) begin
          case (k)
            0:       op = OP_OPEN_RX;
            1:       op = $urandom_range(1) ? OP_EST_RESP : OP_EST_REJ;
            default: op = OP_CLOSE_RX;
          endcase
          if ($urandom_range(6) == 0) op = OP_W'($urandom_range(OP_OPEN_CONF, OP_EST_RESP));
          send_item(op, ch, 1'($urandom_range(1)), CAUSE_W'($urandom_range(15)));
        end
        sent += 3;
      end else begin
        send_item(OP_W'($urandom_range(15)), CH_W'($urandom_range(CH_SPAN - 1)),
                  1'($urandom_range(1)), CAUSE_W'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= '0;
    in_ch.channel      <= '0;
    in_ch.build_ok     <= 1'b0;
    in_ch.reject_cause <= '0;
    send_idle = 13;
    recv_idle = 54;
    hold_out  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // outgoing lifecycle, refusals and errors
    send_item(OP_EST_REQ,   6'd0,  1'b0, 4'd0);
    send_item(OP_EST_REQ,   6'd0,  1'b1, 4'd15);
    send_item(OP_EST_REQ,   6'd0,  1'b1, 4'd0);
    send_item(OP_OPEN_ACK,  6'd0,  1'b0, 4'd0);
    send_item(OP_OPEN_ACK,  6'd0,  1'b0, 4'd0);
    send_item(OP_REL_REQ,   6'd0,  1'b0, 4'd0);
    send_item(OP_OPEN_ACK,  6'd0,  1'b0, 4'd0);
    send_item(OP_CLOSE_ACK, 6'd0,  1'b0, 4'd0);
    send_item(OP_OPEN_REJ,  6'd0,  1'b0, 4'd0);
    send_item(OP_CLOSE_ACK, 6'd0,  1'b0, 4'd0);
    send_item(OP_EST_REQ,   6'd63, 1'b1, 4'd0);
    send_item(OP_OPEN_REJ,  6'd63, 1'b0, 4'd0);
    send_item(OP_EST_REQ,   6'd1,  1'b1, 4'd0);
    send_item(OP_OPEN_ACK,  6'd1,  1'b0, 4'd0);
    send_item(OP_CLOSE_ACK, 6'd1,  1'b0, 4'd0);
    // incoming lifecycle
    send_item(OP_OPEN_RX,   6'd63, 1'b0, 4'd0);
    send_item(OP_OPEN_RX,   6'd63, 1'b0, 4'd0);
    send_item(OP_EST_RESP,  6'd63, 1'b0, 4'd0);
    send_item(OP_CLOSE_RX,  6'd63, 1'b0, 4'd0);
    send_item(OP_CLOSE_RX,  6'd63, 1'b0, 4'd0);
    send_item(OP_OPEN_RX,   6'd63, 1'b0, 4'd0);
    send_item(OP_EST_REJ,   6'd63, 1'b1, 4'd15);
    send_item(OP_OPEN_CONF, 6'd63, 1'b0, 4'd0);
    // an unknown operation and an absent channel
    send_item(4'd15,        6'd42, 1'b1, 4'd15);
    send_item(OP_REL_REQ,   6'd42, 1'b1, 4'd0);
    drain_results();

    random_items(200);
    drain_results();

    // long receiver hold-off while the sender keeps offering
    hold_out  = 1'b1;
    send_idle = 0;
    random_items(16);
    send_idle = 13;
    random_items(60);
    drain_results();

    send_idle = 54;
    recv_idle = 13;
    random_items(260);
    drain_results();

    send_idle = 0;
    recv_idle = 0;
    random_items(260);
    drain_results();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lcsf_pkg.sv
hw/rtl/lcsf_ifs.sv
hw/rtl/lcsf_ctrl.sv
hw/rtl/lcsf_dp.sv
hw/rtl/logical_channel_signalling_fsm.sv
hw/rtl/lcsf_chk.sv
sim/lcsf_action_checker.sv
sim/tb_top.sv
